// ===== src/mips_mult_div_unit_two_pipes_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef MIPS_MULT_DIV_UNIT_TWO_PIPES_DEFINES_SVH
`define MIPS_MULT_DIV_UNIT_TWO_PIPES_DEFINES_SVH

`ifndef SYNTHESIS

`define MMDU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define MMDU_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define MMDU_ASSERT(name, prop, msg)

`define MMDU_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ===== src/mmdu_pkg.sv =====
`timescale 1ns / 1ps

package mmdu_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(WORD_W - 1);

   typedef enum logic [2:0] {
      OP_MULT  = 3'd0,
      OP_MULTU = 3'd1,
      OP_DIV   = 3'd2,
      OP_DIVU  = 3'd3,
      OP_MADD  = 3'd4,
      OP_MADDU = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FIX,
      ST_ACC,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } iter_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage

// ===== src/mmdu_iter.sv =====
`timescale 1ns / 1ps

`include "mips_mult_div_unit_two_pipes_defines.svh"

module mmdu_iter
   import mmdu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  iter_ctrl_type         ctrl,
   input  logic [WORD_W-1:0]     a_mag,
   input  logic [WORD_W-1:0]     b_mag,
   output logic [2*WORD_W-1:0]   work,
   output iter_stat_type         stat
);

   // work_ff: {hi, lo}. Multiply: shift-add, multiplier in lo.
   // Divide: restoring, remainder in hi, dividend/quotient in lo.
   logic [2*WORD_W-1:0] work_ff, work_in;
   logic [WORD_W-1:0]   opnd_ff, opnd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic                div_ff, div_in;

   logic [WORD_W-1:0]   hi_w, lo_w;
   logic [WORD_W:0]     add_sum;
   logic [WORD_W:0]     sub_diff;

   assign hi_w = work_ff[2*WORD_W-1:WORD_W];
   assign lo_w = work_ff[WORD_W-1:0];

   assign add_sum  = {1'b0, hi_w} + (lo_w[0] ? {1'b0, opnd_ff} : '0);
   assign sub_diff = {hi_w, lo_w[WORD_W-1]} - {1'b0, opnd_ff};

   always_comb begin
      work_in = work_ff;
      opnd_in = opnd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         work_in = {{WORD_W{1'b0}}, a_mag};
         opnd_in = b_mag;
         cnt_in  = '0;
         run_in  = 1'b1;
         div_in  = ctrl.is_div;
      end else if (run_ff) begin
         if (div_ff) begin
            if (!sub_diff[WORD_W]) begin
               work_in = {sub_diff[WORD_W-1:0], lo_w[WORD_W-2:0], 1'b1};
            end else begin
               work_in = {hi_w[WORD_W-2:0], lo_w[WORD_W-1], lo_w[WORD_W-2:0], 1'b0};
            end
         end else begin
            work_in = {add_sum, lo_w[WORD_W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      opnd_ff <= opnd_in;
      div_ff  <= div_in;
   end

   assign work      = work_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

   `MMDU_ASSERT(a_iter_no_restart, !(ctrl.start && run_ff), "start while iterating")
   `MMDU_ASSERT_NEXT(a_iter_done_end, run_ff && (cnt_ff == STEP_LAST), done_ff && !run_ff,
      "iteration did not finish after last step")
   `MMDU_ASSERT(a_iter_done_idle, !(done_ff && run_ff), "done while still iterating")

endmodule

// ===== src/mips_mult_div_unit_two_pipes.sv =====
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                 tuser (low bit up)
// req_     in   rs_value[31:0], rt_value[63:32]    opcode[2:0], pipe_select[3]
// rsp_     out  lo_result[31:0], hi_result[63:32]  pipe_written[0], writes_dest[1]
//
// One item at a time: the next item is accepted only after the core has made the 32
// passes of the shared bit-serial shift-add / restoring-subtract unit (MADD/MADDU also accumulate).
// The result register frees the core: a new item is taken while a result waits.
// A result stalled on rsp_tready holds the core in its write-back state.
// Undefined opcodes are accepted and dropped. Reset clears both HI/LO pairs.

`include "mips_mult_div_unit_two_pipes_defines.svh"

module mips_mult_div_unit_two_pipes
   import mmdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // rs_value, rt_value
   input  logic [3:0]  req_tuser,   // opcode, pipe_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // lo_result, hi_result
   output logic [1:0]  rsp_tuser    // pipe_written, writes_dest
);

   state_type state_ff, state_in;

   logic [2:0]          op_ff;
   logic                sel_ff;
   logic [WORD_W-1:0]   rs_ff, rt_ff;
   logic                neg_p_ff, neg_q_ff, neg_r_ff;
   logic [2*WORD_W-1:0] res_ff, res_in;
   logic [WORD_W-1:0]   lo_words_ff [2];
   logic [WORD_W-1:0]   hi_words_ff [2];
   logic                rsp_valid_ff;
   logic [63:0]         rsp_data_ff;
   logic [1:0]          rsp_user_ff;

   logic                req_fire;
   logic                op_ok;
   logic                is_signed, is_div, is_acc;
   logic [WORD_W-1:0]   a_mag, b_mag;
   logic                out_free;
   iter_ctrl_type       iter_ctrl;
   iter_stat_type       iter_stat;
   logic [2*WORD_W-1:0] work;
   logic [WORD_W-1:0]   wk_hi, wk_lo;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      op_ok = (req_tuser[2:0] == OP_MULT) || (req_tuser[2:0] == OP_MULTU) ||
              (req_tuser[2:0] == OP_DIV) || (req_tuser[2:0] == OP_DIVU) ||
              (req_tuser[2:0] == OP_MADD) || (req_tuser[2:0] == OP_MADDU);
   end

   always_comb begin
      is_signed = 1'b0;
      is_div    = 1'b0;
      is_acc    = 1'b0;
      unique case (op_ff)
         OP_MULT:  is_signed = 1'b1;
         OP_MULTU: ;
         OP_DIV: begin
            is_signed = 1'b1;
            is_div    = 1'b1;
         end
         OP_DIVU:  is_div = 1'b1;
         OP_MADD: begin
            is_signed = 1'b1;
            is_acc    = 1'b1;
         end
         OP_MADDU: is_acc = 1'b1;
         default: ;
      endcase
   end

   assign a_mag = (is_signed && rs_ff[WORD_W-1]) ? (~rs_ff + 1'b1) : rs_ff;
   assign b_mag = (is_signed && rt_ff[WORD_W-1]) ? (~rt_ff + 1'b1) : rt_ff;

   mmdu_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ctrl  (iter_ctrl),
      .a_mag (a_mag),
      .b_mag (b_mag),
      .work  (work),
      .stat  (iter_stat)
   );

   assign wk_hi = work[2*WORD_W-1:WORD_W];
   assign wk_lo = work[WORD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && op_ok) state_in = ST_PREP;
         ST_PREP:  state_in = ST_RUN;
         ST_RUN:   if (iter_stat.done) state_in = ST_FIX;
         ST_FIX:   state_in = is_acc ? ST_ACC : ST_WRITE;
         ST_ACC:   state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready       = 1'b0;
      iter_ctrl.start  = 1'b0;
      iter_ctrl.is_div = is_div;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_PREP:  iter_ctrl.start = 1'b1;
         ST_RUN, ST_FIX, ST_ACC, ST_WRITE: ;
         default: ;
      endcase
   end

   always_comb begin
      res_in = res_ff;
      unique case (state_ff)
         ST_FIX: begin
            if (is_div) begin
               res_in = {(neg_r_ff ? (~wk_hi + 1'b1) : wk_hi),
                         (neg_q_ff ? (~wk_lo + 1'b1) : wk_lo)};
            end else begin
               res_in = neg_p_ff ? (~work + 1'b1) : work;
            end
         end
         ST_ACC:  res_in = res_ff + {hi_words_ff[sel_ff], lo_words_ff[sel_ff]};
         ST_IDLE, ST_PREP, ST_RUN, ST_WRITE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         lo_words_ff[0] <= '0;
         lo_words_ff[1] <= '0;
         hi_words_ff[0] <= '0;
         hi_words_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WRITE && out_free) begin
            rsp_valid_ff        <= 1'b1;
            lo_words_ff[sel_ff] <= res_ff[WORD_W-1:0];
            hi_words_ff[sel_ff] <= res_ff[2*WORD_W-1:WORD_W];
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (req_fire) begin
         op_ff  <= req_tuser[2:0];
         sel_ff <= req_tuser[3];
         rs_ff  <= req_tdata[WORD_W-1:0];
         rt_ff  <= req_tdata[2*WORD_W-1:WORD_W];
      end
      if (state_ff == ST_PREP) begin
         neg_p_ff <= is_signed && (rs_ff[WORD_W-1] ^ rt_ff[WORD_W-1]);
         neg_q_ff <= is_signed && (rs_ff[WORD_W-1] ^ rt_ff[WORD_W-1]);
         neg_r_ff <= is_signed && rs_ff[WORD_W-1];
      end
      if (state_ff == ST_WRITE && out_free) begin
         rsp_data_ff <= res_ff;
         rsp_user_ff <= {!is_div, sel_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MMDU_ASSERT(a_done_in_run, iter_stat.done |-> (state_ff == ST_RUN),
      "iteration finished outside run state")
   `MMDU_ASSERT(a_busy_in_run, iter_stat.busy |-> (state_ff == ST_RUN),
      "iteration running outside run state")
   `MMDU_ASSERT(a_rsp_from_write, $rose(rsp_tvalid) |-> $past(state_ff == ST_WRITE),
      "item raised outside write-back")
   `MMDU_ASSERT_NEXT(a_pairs_hold, state_ff != ST_WRITE,
      $stable(lo_words_ff[0]) && $stable(lo_words_ff[1]) &&
      $stable(hi_words_ff[0]) && $stable(hi_words_ff[1]),
      "HI/LO changed outside write-back")

endmodule

// ===== verif/tb_mips_mult_div_unit_two_pipes.sv =====
`timescale 1ns / 1ps

module tb_mips_mult_div_unit_two_pipes
   import mmdu_pkg::*;
();

   localparam logic [2:0]  OP_RSVD_A   = 3'd6;
   localparam logic [2:0]  OP_RSVD_B   = 3'd7;
   localparam logic [31:0] SIGN_WORD   = 32'h8000_0000;
   localparam logic [31:0] ONES_WORD   = 32'hffff_ffff;
   localparam logic [31:0] MAX_POS     = 32'h7fff_ffff;
   localparam int          RANDOM_OPS  = 1550;
   localparam int          HOLD_CYCLES = 300;
   localparam int          DRAIN_TAIL  = 60;
   localparam int          IDLE_LIMIT  = 4000;

   class hilo_scoreboard;
      typedef struct {
         logic [31:0] lo;
         logic [31:0] hi;
         logic        pipe;
         logic        dest;
      } hilo_result_t;

      logic [31:0]  lo_words [2];
      logic [31:0]  hi_words [2];
      hilo_result_t pending [$];
      int           errors;

      function new();
         lo_words = '{32'd0, 32'd0};
         hi_words = '{32'd0, 32'd0};
         errors   = 0;
      endfunction

      function void note_request(logic [2:0] op, logic sel, logic [31:0] a, logic [31:0] b);
         logic [63:0]  ea, eb, prod;
         logic [31:0]  ma, mb, mq, mr;
         logic         sgn;
         hilo_result_t res;
         res.pipe = sel;
         case (op)
            OP_MULT, OP_MULTU, OP_MADD, OP_MADDU: begin
               sgn  = (op == OP_MULT) || (op == OP_MADD);
               ea   = sgn ? {{32{a[31]}}, a} : {32'd0, a};
               eb   = sgn ? {{32{b[31]}}, b} : {32'd0, b};
               prod = ea * eb;
               if (op == OP_MADD || op == OP_MADDU)
                  prod = prod + {hi_words[sel], lo_words[sel]};
               res.lo   = prod[31:0];
               res.hi   = prod[63:32];
               res.dest = 1'b1;
            end
            OP_DIV: begin
               if (a == SIGN_WORD && b == ONES_WORD) begin
                  res.lo = SIGN_WORD;
                  res.hi = 32'd0;
               end else if (b == 32'd0) begin
                  res.lo = a[31] ? 32'd1 : ONES_WORD;
                  res.hi = a;
               end else begin
                  ma     = a[31] ? (32'd0 - a) : a;
                  mb     = b[31] ? (32'd0 - b) : b;
                  mq     = ma / mb;
                  mr     = ma % mb;
                  res.lo = (a[31] != b[31]) ? (32'd0 - mq) : mq;
                  res.hi = a[31] ? (32'd0 - mr) : mr;
               end
               res.dest = 1'b0;
            end
            OP_DIVU: begin
               if (b == 32'd0) begin
                  res.lo = ONES_WORD;
                  res.hi = a;
               end else begin
                  res.lo = a / b;
                  res.hi = a % b;
               end
               res.dest = 1'b0;
            end
            default: return;
         endcase
         lo_words[sel] = res.lo;
         hi_words[sel] = res.hi;
         pending.push_back(res);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_response(logic [31:0] lo, logic [31:0] hi, logic pipe, logic dest);
         hilo_result_t exp_res;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected item lo %h hi %h", lo, hi));
            return;
         end
         exp_res = pending.pop_front();
         if (lo !== exp_res.lo)
            report_mismatch($sformatf("lo_result %h, want %h", lo, exp_res.lo));
         if (hi !== exp_res.hi)
            report_mismatch($sformatf("hi_result %h, want %h", hi, exp_res.hi));
         if (pipe !== exp_res.pipe)
            report_mismatch($sformatf("pipe_written %b, want %b", pipe, exp_res.pipe));
         if (dest !== exp_res.dest)
            report_mismatch($sformatf("writes_dest %b, want %b", dest, exp_res.dest));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // rs_value, rt_value
   logic [3:0]  req_tuser;   // opcode, pipe_select
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // lo_result, hi_result
   logic [1:0]  rsp_tuser;   // pipe_written, writes_dest

   hilo_scoreboard board = new();
   bit             hold_req;
   int             idle_cycles;

   mips_mult_div_unit_two_pipes dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return ONES_WORD;
         3: return SIGN_WORD;
         4: return MAX_POS;
         5: return 32'($urandom_range(0, 255));
         6: return 32'd0 - 32'($urandom_range(1, 255));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(logic [2:0] op, logic sel, logic [31:0] a, logic [31:0] b);
      int gap;
      gap        = gap_len();
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= {sel, op};
      do
         @(posedge clock);
      while (!req_tready);
      board.note_request(op, sel, a, b);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      if (board.pending.size() != 0) begin
         req_tvalid <= 1'b0;
         while (board.pending.size() != 0)
            @(posedge clock);
      end
   endtask

   // receiver: random ready runs, random stalls, long hold on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         n = gap_len();
         if (hold_req) begin
            n        = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [2:0] op;
      int         ops_done;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      hold_req   = 1'b0;
      idle_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_item(OP_MULT,   1'b0, SIGN_WORD, SIGN_WORD);
      send_item(OP_MULT,   1'b1, ONES_WORD, ONES_WORD);
      send_item(OP_MULT,   1'b0, MAX_POS, SIGN_WORD);
      send_item(OP_MULTU,  1'b1, ONES_WORD, ONES_WORD);
      send_item(OP_MULTU,  1'b0, 32'd0, ONES_WORD);
      send_item(OP_DIV,    1'b0, SIGN_WORD, ONES_WORD);   // overflow
      send_item(OP_DIV,    1'b1, 32'd5, 32'd0);           // div by zero, positive
      send_item(OP_DIV,    1'b0, 32'h8000_0005, 32'd0);   // div by zero, negative
      send_item(OP_DIV,    1'b1, 32'd0, 32'd0);
      send_item(OP_DIV,    1'b0, 32'hffff_fff9, 32'd2);
      send_item(OP_DIV,    1'b1, 32'd7, 32'hffff_fffe);
      send_item(OP_DIVU,   1'b0, 32'h1234_5678, 32'd0);
      send_item(OP_DIVU,   1'b1, ONES_WORD, 32'd1);
      send_item(OP_DIVU,   1'b0, 32'd7, ONES_WORD);
      send_item(OP_MULTU,  1'b0, ONES_WORD, ONES_WORD);
      send_item(OP_MADDU,  1'b0, ONES_WORD, ONES_WORD);   // 64-bit wrap
      send_item(OP_MADDU,  1'b0, ONES_WORD, ONES_WORD);
      send_item(OP_MADD,   1'b1, ONES_WORD, 32'd1);
      send_item(OP_MADD,   1'b1, SIGN_WORD, SIGN_WORD);
      send_item(OP_RSVD_A, 1'b0, ONES_WORD, ONES_WORD);
      send_item(OP_RSVD_B, 1'b1, ONES_WORD, ONES_WORD);
      send_item(OP_MADD,   1'b0, MAX_POS, MAX_POS);

      ops_done = 0;
      while (ops_done < RANDOM_OPS) begin
         if ($urandom_range(0, 99) < 5)
            op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
         else begin
            op = 3'($urandom_range(0, 5));
            ops_done++;
            if (ops_done == 400 || ops_done == 1300)
               hold_req = 1'b1;
            if (ops_done == 900)
               wait_drained();
         end
         send_item(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand());
      end

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/mmdu_pkg.sv
src/mmdu_iter.sv
src/mips_mult_div_unit_two_pipes.sv
verif/tb_mips_mult_div_unit_two_pipes.sv
